FILE: design/x86d_pkg.sv
// Package for the 16-bit x86 instruction decoder.
// Holds the phase and kind codes, the decoded record type and the opcode helper functions.
// No dependencies.
package x86d_pkg;

  // opcode patterns of the supported forms
  localparam logic [7:0] MOV_IMM_PREFIX = 8'b10110000;
  localparam logic [7:0] MOV_RM_PREFIX  = 8'b10001000;
  localparam logic [7:0] ADD_RM_MASK    = 8'b11111100;
  localparam logic [7:0] ADD_IMM_PREFIX = 8'b10000000;
  localparam logic [7:0] ADD_ACC_PREFIX = 8'b00000100;
  localparam logic [7:0] MOD_MASK       = 8'b11000000;
  localparam logic [7:0] REG_MASK       = 8'b00111000;

  // byte collection phase
  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_MODRM  = 3'd1,
    PH_DISP   = 3'd2,
    PH_IMM    = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  // instruction kind as reported in the record
  typedef enum logic [2:0] {
    KIND_MOV_RM   = 3'd0,
    KIND_MOV_IMM  = 3'd1,
    KIND_ADD_RM   = 3'd2,
    KIND_ADD_IMM  = 3'd3,
    KIND_ADD_ACC  = 3'd4,
    KIND_UNKNOWN  = 3'd5
  } kind_t;

  // one decoded instruction
  typedef struct packed {
    kind_t       op_kind;
    logic        wide;
    logic        dir_or_sign;
    logic [1:0]  mode;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
  } rec_t;

  // classify an opcode by exact prefix
  function automatic kind_t kind_of(input logic [7:0] op);
    kind_t k;
    if ((op & 8'hFC) == MOV_RM_PREFIX) begin
      k = KIND_MOV_RM;
    end else if ((op & 8'hF0) == MOV_IMM_PREFIX) begin
      k = KIND_MOV_IMM;
    end else if ((op & ADD_RM_MASK) == 8'h00) begin
      k = KIND_ADD_RM;
    end else if ((op & 8'hFC) == ADD_IMM_PREFIX) begin
      k = KIND_ADD_IMM;
    end else if ((op & 8'hFE) == ADD_ACC_PREFIX) begin
      k = KIND_ADD_ACC;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

  // displacement bytes that follow a mod-reg-rm byte
  function automatic logic [1:0] disp_count(input logic [7:0] modrm);
    logic [1:0] md;
    logic [1:0] n;
    md = modrm[7:6];
    case (md)
      2'd1:    n = 2'd1;
      2'd2:    n = 2'd2;
      2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // immediate bytes of an opcode
  function automatic logic [1:0] imm_count(input logic [7:0] op);
    logic [1:0] n;
    case (kind_of(op))
      KIND_MOV_IMM: n = op[3] ? 2'd2 : 2'd1;
      KIND_ADD_IMM: n = (op[1:0] == 2'd1) ? 2'd2 : 2'd1;
      KIND_ADD_ACC: n = op[0] ? 2'd2 : 2'd1;
      default:      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: design/x86d_seq.sv
// Byte collection state and record formation of the x86 decoder.
// Updates the held instruction bytes on each accepted transaction and forms the record.
// Depends on x86d_pkg.
module x86d_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        code_byte,
  input  logic              end_of_code,
  output logic              rec_emit,
  output x86d_pkg::rec_t    rec
);

  x86d_pkg::phase_t phase_r, phase_upd, phase_nxt;
  logic [7:0]  op_r, op_upd, op_nxt;
  logic [7:0]  modrm_r, modrm_upd, modrm_nxt;
  logic [1:0]  dleft_r, dleft_upd, dleft_nxt;
  logic [1:0]  ileft_r, ileft_upd, ileft_nxt;
  logic [15:0] disp_r, disp_upd, disp_nxt;
  logic [15:0] imm_r, imm_upd, imm_nxt;
  logic        emit;
  logic [1:0]  dc_b;
  logic [1:0]  ic_op;
  x86d_pkg::kind_t kind_b;

  assign dc_b   = x86d_pkg::disp_count(code_byte);
  assign ic_op  = x86d_pkg::imm_count(op_r);
  assign kind_b = x86d_pkg::kind_of(code_byte);

  // next state for one byte
  always_comb begin
    phase_upd = phase_r;
    op_upd    = op_r;
    modrm_upd = modrm_r;
    dleft_upd = dleft_r;
    ileft_upd = ileft_r;
    disp_upd  = disp_r;
    imm_upd   = imm_r;
    emit      = 1'b0;
    case (phase_r)
      x86d_pkg::PH_MODRM: begin
        modrm_upd = code_byte;
        if (dc_b != 2'd0) begin
          dleft_upd = dc_b;
          phase_upd = x86d_pkg::PH_DISP;
        end else if (ic_op != 2'd0) begin
          ileft_upd = ic_op;
          phase_upd = x86d_pkg::PH_IMM;
        end else begin
          emit      = 1'b1;
          phase_upd = x86d_pkg::PH_OPCODE;
        end
      end
      x86d_pkg::PH_DISP: begin
        if (dleft_r == x86d_pkg::disp_count(modrm_r)) begin
          disp_upd = {8'h00, code_byte};
        end else begin
          disp_upd = {code_byte, disp_r[7:0]};
        end
        dleft_upd = dleft_r - 2'd1;
        if (dleft_upd == 2'd0) begin
          if (ic_op != 2'd0) begin
            ileft_upd = ic_op;
            phase_upd = x86d_pkg::PH_IMM;
          end else begin
            emit      = 1'b1;
            phase_upd = x86d_pkg::PH_OPCODE;
          end
        end
      end
      x86d_pkg::PH_IMM: begin
        if (ileft_r == ic_op) begin
          imm_upd = {8'h00, code_byte};
        end else begin
          imm_upd = {code_byte, imm_r[7:0]};
        end
        ileft_upd = ileft_r - 2'd1;
        if (ileft_upd == 2'd0) begin
          emit      = 1'b1;
          phase_upd = x86d_pkg::PH_OPCODE;
        end
      end
      x86d_pkg::PH_SKIP: begin
        emit      = 1'b1;
        phase_upd = x86d_pkg::PH_OPCODE;
      end
      default: begin
        // awaiting opcode, also the unused phase codes
        op_upd    = code_byte;
        modrm_upd = 8'h00;
        disp_upd  = 16'h0000;
        imm_upd   = 16'h0000;
        dleft_upd = 2'd0;
        ileft_upd = 2'd0;
        case (kind_b)
          x86d_pkg::KIND_MOV_RM, x86d_pkg::KIND_ADD_RM, x86d_pkg::KIND_ADD_IMM: begin
            phase_upd = x86d_pkg::PH_MODRM;
          end
          x86d_pkg::KIND_MOV_IMM, x86d_pkg::KIND_ADD_ACC: begin
            ileft_upd = x86d_pkg::imm_count(code_byte);
            phase_upd = x86d_pkg::PH_IMM;
          end
          default: begin
            phase_upd = x86d_pkg::PH_SKIP;
          end
        endcase
      end
    endcase
  end

  // end flag drops any partial instruction after this byte
  always_comb begin
    if (end_of_code) begin
      phase_nxt = x86d_pkg::PH_OPCODE;
      op_nxt    = 8'h00;
      modrm_nxt = 8'h00;
      dleft_nxt = 2'd0;
      ileft_nxt = 2'd0;
      disp_nxt  = 16'h0000;
      imm_nxt   = 16'h0000;
    end else begin
      phase_nxt = phase_upd;
      op_nxt    = op_upd;
      modrm_nxt = modrm_upd;
      dleft_nxt = dleft_upd;
      ileft_nxt = ileft_upd;
      disp_nxt  = disp_upd;
      imm_nxt   = imm_upd;
    end
  end

  // record formed from the updated held bytes
  always_comb begin
    x86d_pkg::kind_t k;
    k   = x86d_pkg::kind_of(op_upd);
    rec = '0;
    rec.op_kind = k;
    case (k)
      x86d_pkg::KIND_MOV_RM, x86d_pkg::KIND_ADD_RM, x86d_pkg::KIND_ADD_IMM: begin
        rec.wide         = op_upd[0];
        rec.dir_or_sign  = op_upd[1];
        rec.mode         = modrm_upd[7:6];
        rec.reg_field    = modrm_upd[5:3];
        rec.rm_field     = modrm_upd[2:0];
        rec.displacement = disp_upd;
        rec.immediate    = imm_upd;
        rec.length       = 3'd2 + {1'b0, x86d_pkg::disp_count(modrm_upd)}
                         + {1'b0, x86d_pkg::imm_count(op_upd)};
      end
      x86d_pkg::KIND_MOV_IMM: begin
        rec.wide         = op_upd[3];
        rec.mode         = 2'd3;
        rec.reg_field    = op_upd[2:0];
        rec.displacement = disp_upd;
        rec.immediate    = imm_upd;
        rec.length       = 3'd1 + {1'b0, x86d_pkg::imm_count(op_upd)};
      end
      x86d_pkg::KIND_ADD_ACC: begin
        rec.wide         = op_upd[0];
        rec.mode         = 2'd3;
        rec.displacement = disp_upd;
        rec.immediate    = imm_upd;
        rec.length       = 3'd1 + {1'b0, x86d_pkg::imm_count(op_upd)};
      end
      default: begin
        rec.length = 3'd2;
      end
    endcase
  end

  assign rec_emit = take & emit;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= x86d_pkg::PH_OPCODE;
      op_r    <= 8'h00;
      modrm_r <= 8'h00;
      dleft_r <= 2'd0;
      ileft_r <= 2'd0;
      disp_r  <= 16'h0000;
      imm_r   <= 16'h0000;
    end else if (take) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      modrm_r <= modrm_nxt;
      dleft_r <= dleft_nxt;
      ileft_r <= ileft_nxt;
      disp_r  <= disp_nxt;
      imm_r   <= imm_nxt;
    end
  end

  // end flag always returns to awaiting an opcode
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_code |=> phase_r == x86d_pkg::PH_OPCODE && op_r == 8'h00)
    else $error("end flag did not clear the decoder state");

  // the unknown second byte always completes an instruction
  a_skip_emits: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == x86d_pkg::PH_SKIP |-> rec_emit && rec.length == 3'd2)
    else $error("unknown instruction did not complete on its second byte");

  // a counted phase never sits with its counter at zero
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == x86d_pkg::PH_DISP |-> dleft_r != 2'd0) and
    (phase_r == x86d_pkg::PH_IMM  |-> ileft_r != 2'd0))
    else $error("byte counter is zero in a counted phase");

endmodule

FILE: design/x86d_out_reg.sv
// Result holding register of the x86 decoder.
// Keeps one decoded record until the consumer takes it; loads while it drains.
// Depends on x86d_pkg.
module x86d_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  x86d_pkg::rec_t  rec_in,
  input  logic            out_ready,
  output logic            out_valid,
  output logic            free,
  output x86d_pkg::rec_t  rec_out
);

  logic           valid_r, valid_nxt;
  x86d_pkg::rec_t rec_r;

  assign free = !valid_r || out_ready;

  // valid follows loads and drains
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

  assign out_valid = valid_r;
  assign rec_out   = rec_r;

endmodule

FILE: design/x86_16bit_instruction_decoder_unit.sv
// Top level of the 16-bit x86 instruction decoder.
// Instantiates x86d_seq (byte collection) and x86d_out_reg (result register); uses x86d_pkg.
//
// Takes one code byte per transaction and emits one decoded record per finished
// instruction (mov r/m, mov imm to reg, add r/m, add imm, add imm to accumulator,
// or unknown taking two bytes). The field update of the collection state is done in
// the cycle the byte is taken, and a finished record is loaded into the result
// register at that same edge, so a record appears in the cycle after the last byte
// of its instruction is taken. A byte is taken whenever the result register
// is empty or being drained; only a record that waits for the consumer stalls input.
// A byte with end_of_code set is decoded as usual, then any partial instruction is
// dropped. Multi-byte displacements and immediates are little-endian; 8-bit ones are
// zero-extended.
module x86_16bit_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic        in_end_of_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_op_kind,
  output logic        out_wide,
  output logic        out_dir_or_sign,
  output logic [1:0]  out_mode,
  output logic [2:0]  out_reg_field,
  output logic [2:0]  out_rm_field,
  output logic [15:0] out_displacement,
  output logic [15:0] out_immediate,
  output logic [2:0]  out_length
);

  logic           take;
  logic           rec_emit;
  logic           free;
  x86d_pkg::rec_t rec;
  x86d_pkg::rec_t rec_q;

  assign in_ready = free;
  assign take     = in_valid && free;

  // byte collection and record formation
  x86d_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .code_byte   (in_code_byte),
    .end_of_code (in_end_of_code),
    .rec_emit    (rec_emit),
    .rec         (rec)
  );

  // result register
  x86d_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (rec_emit),
    .rec_in    (rec),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .rec_out   (rec_q)
  );

  assign out_op_kind      = rec_q.op_kind;
  assign out_wide         = rec_q.wide;
  assign out_dir_or_sign  = rec_q.dir_or_sign;
  assign out_mode         = rec_q.mode;
  assign out_reg_field    = rec_q.reg_field;
  assign out_rm_field     = rec_q.rm_field;
  assign out_displacement = rec_q.displacement;
  assign out_immediate    = rec_q.immediate;
  assign out_length       = rec_q.length;

  // a waiting record blocks input so it cannot be overwritten
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a record waits");

  // a record leaves with a legal length
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length >= 3'd1 && out_length <= 3'd6)
    else $error("record length out of range");

  // an unknown record carries nothing but kind and length
  a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_kind == x86d_pkg::KIND_UNKNOWN |->
      out_length == 3'd2 && out_displacement == 16'h0000 && out_immediate == 16'h0000)
    else $error("unknown record has stray fields");

endmodule

FILE: tb/sv/x86d_decode_checker.sv
// Scoreboard for the x86 instruction decoder: follows the byte and record channels.
// Keeps its own decoder state, queues the record due for each byte and compares.
// Depends on x86d_pkg for the record, kind and phase types and the opcode constants.
module x86d_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic        in_end_of_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_op_kind,
  input  logic        out_wide,
  input  logic        out_dir_or_sign,
  input  logic [1:0]  out_mode,
  input  logic [2:0]  out_reg_field,
  input  logic [2:0]  out_rm_field,
  input  logic [15:0] out_displacement,
  input  logic [15:0] out_immediate,
  input  logic [2:0]  out_length,
  output int          mismatches,
  output int          awaited,
  output int          records_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // mod value that selects a register operand, rm value of a direct address
  localparam logic [1:0] MODE_REG  = 2'd3;
  localparam logic [2:0] RM_DIRECT = 3'd6;

  // decoder state as the scoreboard sees it
  x86d_pkg::phase_t phase;
  logic [7:0]  opcode_q;
  logic [7:0]  modrm_q;
  logic [1:0]  disp_left;
  logic [1:0]  imm_left;
  logic [15:0] disp_q;
  logic [15:0] imm_q;

  x86d_pkg::rec_t expected_records[$];
  int   errors_q = 0;
  int   checked_q = 0;

  // opcode class from the fixed high bits of each form
  function automatic x86d_pkg::kind_t classify(input logic [7:0] op);
    if ((op & 8'hFC) == x86d_pkg::MOV_RM_PREFIX) return x86d_pkg::KIND_MOV_RM;
    if ((op & 8'hF0) == x86d_pkg::MOV_IMM_PREFIX) return x86d_pkg::KIND_MOV_IMM;
    if (op[7:2] == 6'b000000) return x86d_pkg::KIND_ADD_RM;
    if ((op & 8'hFC) == x86d_pkg::ADD_IMM_PREFIX) return x86d_pkg::KIND_ADD_IMM;
    if ((op & 8'hFE) == x86d_pkg::ADD_ACC_PREFIX) return x86d_pkg::KIND_ADD_ACC;
    return x86d_pkg::KIND_UNKNOWN;
  endfunction

  // displacement length implied by mod and rm
  function automatic int unsigned disp_bytes(input logic [7:0] m);
    case (m[7:6])
      2'd1:    return 1;
      2'd2:    return 2;
      2'd0:    return (m[2:0] == RM_DIRECT) ? 2 : 0;
      default: return 0;
    endcase
  endfunction

  // immediate length; add imm is short unless s=0 and w=1
  function automatic int unsigned imm_bytes(input logic [7:0] op);
    case (classify(op))
      x86d_pkg::KIND_MOV_IMM: return op[3] ? 2 : 1;
      x86d_pkg::KIND_ADD_IMM: return (op[1:0] == 2'b01) ? 2 : 1;
      x86d_pkg::KIND_ADD_ACC: return op[0] ? 2 : 1;
      default:                return 0;
    endcase
  endfunction

  function automatic void clear_state();
    phase = x86d_pkg::PH_OPCODE;
    opcode_q = '0;
    modrm_q = '0;
    disp_left = '0;
    imm_left = '0;
    disp_q = '0;
    imm_q = '0;
  endfunction

  // record for the instruction now held
  function automatic x86d_pkg::rec_t build_record();
    x86d_pkg::rec_t  r;
    x86d_pkg::kind_t k;
    r = '0;
    k = classify(opcode_q);
    r.op_kind = k;
    r.displacement = disp_q;
    r.immediate = imm_q;
    case (k)
      x86d_pkg::KIND_MOV_RM, x86d_pkg::KIND_ADD_RM, x86d_pkg::KIND_ADD_IMM: begin
        r.wide = opcode_q[0];
        r.dir_or_sign = opcode_q[1];
        r.mode = modrm_q[7:6];
        r.reg_field = modrm_q[5:3];
        r.rm_field = modrm_q[2:0];
        r.length = 3'(2 + disp_bytes(modrm_q) + imm_bytes(opcode_q));
      end
      x86d_pkg::KIND_MOV_IMM: begin
        r.wide = opcode_q[3];
        r.mode = MODE_REG;
        r.reg_field = opcode_q[2:0];
        r.length = 3'(1 + imm_bytes(opcode_q));
      end
      x86d_pkg::KIND_ADD_ACC: begin
        r.wide = opcode_q[0];
        r.mode = MODE_REG;
        r.length = 3'(1 + imm_bytes(opcode_q));
      end
      default: begin
        r.displacement = '0;
        r.immediate = '0;
        r.length = 3'd2;
      end
    endcase
    return r;
  endfunction

  // displacement done or absent: move on to the immediate or report completion
  function automatic bit operands_done();
    if (imm_bytes(opcode_q) != 0) begin
      imm_left = 2'(imm_bytes(opcode_q));
      phase = x86d_pkg::PH_IMM;
      return 1'b0;
    end
    phase = x86d_pkg::PH_OPCODE;
    return 1'b1;
  endfunction

  // advance the decoder by one code byte, queue a record when one completes
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    bit              finished;
    x86d_pkg::kind_t k;
    finished = 1'b0;
    case (phase)
      x86d_pkg::PH_MODRM: begin
        modrm_q = b;
        if (disp_bytes(b) != 0) begin
          disp_left = 2'(disp_bytes(b));
          phase = x86d_pkg::PH_DISP;
        end else begin
          finished = operands_done();
        end
      end
      x86d_pkg::PH_DISP: begin
        // little-endian: low byte first
        if (disp_left == disp_bytes(modrm_q)) disp_q = {8'h00, b};
        else disp_q[15:8] = b;
        disp_left = disp_left - 2'd1;
        if (disp_left == 2'd0) finished = operands_done();
      end
      x86d_pkg::PH_IMM: begin
        if (imm_left == imm_bytes(opcode_q)) imm_q = {8'h00, b};
        else imm_q[15:8] = b;
        imm_left = imm_left - 2'd1;
        if (imm_left == 2'd0) begin
          finished = 1'b1;
          phase = x86d_pkg::PH_OPCODE;
        end
      end
      x86d_pkg::PH_SKIP: begin
        finished = 1'b1;
        phase = x86d_pkg::PH_OPCODE;
      end
      default: begin
        clear_state();
        opcode_q = b;
        k = classify(b);
        case (k)
          x86d_pkg::KIND_MOV_RM, x86d_pkg::KIND_ADD_RM, x86d_pkg::KIND_ADD_IMM:
            phase = x86d_pkg::PH_MODRM;
          x86d_pkg::KIND_MOV_IMM, x86d_pkg::KIND_ADD_ACC: begin
            imm_left = 2'(imm_bytes(b));
            phase = x86d_pkg::PH_IMM;
          end
          default: phase = x86d_pkg::PH_SKIP;
        endcase
      end
    endcase
    if (finished) expected_records.push_back(build_record());
    // end flag drops whatever is left of a partial instruction
    if (last) clear_state();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_q++;
    end
  endtask

  // byte transactions feed the model, record transactions are checked in order
  always @(posedge clk) begin
    x86d_pkg::rec_t want;
    if (!rst_n) begin
      clear_state();
      expected_records.delete();
    end else begin
      if (in_valid && in_ready) absorb_byte(in_code_byte, in_end_of_code);
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          $error("record transaction with nothing expected: kind %0d length %0d",
                 out_op_kind, out_length);
          errors_q++;
        end else begin
          want = expected_records.pop_front();
          check_field("op_kind", 16'(want.op_kind), 16'(out_op_kind));
          check_field("wide", 16'(want.wide), 16'(out_wide));
          check_field("dir_or_sign", 16'(want.dir_or_sign), 16'(out_dir_or_sign));
          check_field("mode", 16'(want.mode), 16'(out_mode));
          check_field("reg_field", 16'(want.reg_field), 16'(out_reg_field));
          check_field("rm_field", 16'(want.rm_field), 16'(out_rm_field));
          check_field("displacement", want.displacement, out_displacement);
          check_field("immediate", want.immediate, out_immediate);
          check_field("length", 16'(want.length), 16'(out_length));
          checked_q++;
        end
      end
    end
    mismatches <= errors_q;
    awaited <= expected_records.size();
    records_checked <= checked_q;
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the x86 decoder testbench: clock, reset, byte stimulus and consumer stalls.
// Instantiates x86_16bit_instruction_decoder_unit and x86d_decode_checker; uses x86d_pkg.
// Directed instructions first, then random instruction streams with noise and cut-offs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SEGMENT_LEN  = 250;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam logic NO_END   = 1'b0;
  localparam logic WITH_END = 1'b1;

  // directed bytes: {end flag, code byte}
  localparam logic [8:0] DIRECTED_BYTES [26] = '{
    {NO_END, 8'h00}, {NO_END, 8'h00},                        // add r/m, all bits low
    {NO_END, x86d_pkg::MOV_RM_PREFIX | 8'h03}, {NO_END, 8'h7F},   // mov, mod 1
    {NO_END, 8'hFF},
    {NO_END, x86d_pkg::ADD_IMM_PREFIX | 8'h01}, {NO_END, 8'h06},  // direct address, word imm
    {NO_END, 8'hAA}, {NO_END, 8'h55}, {NO_END, 8'h01}, {NO_END, 8'h80},
    {NO_END, x86d_pkg::ADD_IMM_PREFIX | 8'h03}, {NO_END, 8'hC5},  // sign bit set, short imm (zero-extended)
    {NO_END, 8'hFF},
    {NO_END, x86d_pkg::MOV_IMM_PREFIX | 8'h0F}, {NO_END, 8'hFF}, {NO_END, 8'hFF},
    {NO_END, x86d_pkg::ADD_ACC_PREFIX}, {NO_END, 8'hFF},
    {NO_END, 8'hFF}, {NO_END, 8'h00},                         // unknown opcode
    {NO_END, x86d_pkg::MOV_RM_PREFIX | 8'h01}, {NO_END, 8'h80},   // cut off in displacement
    {WITH_END, 8'h11},
    {NO_END, x86d_pkg::MOV_IMM_PREFIX}, {WITH_END, 8'h5A}     // end on a finished one
  };

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_code_byte = 8'h00;
  logic        in_end_of_code = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_op_kind;
  logic        out_wide;
  logic        out_dir_or_sign;
  logic [1:0]  out_mode;
  logic [2:0]  out_reg_field;
  logic [2:0]  out_rm_field;
  logic [15:0] out_displacement;
  logic [15:0] out_immediate;
  logic [2:0]  out_length;

  int mismatches;
  int awaited;
  int records_checked;
  int cycle_count = 0;
  int bytes_sent = 0;
  int end_flags_sent = 0;
  int burst_left = 0;
  bit offering = 1'b0;
  logic [7:0] instr_bytes[$];

  x86_16bit_instruction_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_code_byte(in_code_byte), .in_end_of_code(in_end_of_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_op_kind(out_op_kind), .out_wide(out_wide), .out_dir_or_sign(out_dir_or_sign),
    .out_mode(out_mode), .out_reg_field(out_reg_field), .out_rm_field(out_rm_field),
    .out_displacement(out_displacement), .out_immediate(out_immediate),
    .out_length(out_length)
  );

  x86d_decode_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_code_byte(in_code_byte), .in_end_of_code(in_end_of_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_op_kind(out_op_kind), .out_wide(out_wide), .out_dir_or_sign(out_dir_or_sign),
    .out_mode(out_mode), .out_reg_field(out_reg_field), .out_rm_field(out_rm_field),
    .out_displacement(out_displacement), .out_immediate(out_immediate),
    .out_length(out_length),
    .mismatches(mismatches), .awaited(awaited), .records_checked(records_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // consumer: open, random, periodic and long hold-off segments in turn
  initial begin
    int       seg;
    rx_mode_t mode;
    seg = 0;
    forever begin
      mode = rx_mode_t'(seg % 4);
      seg++;
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        case (mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ready <= ((k % 5) < 2);
          default:    out_ready <= (k >= HOLD_CYCLES);
        endcase
        @(posedge clk);
      end
    end
  end

  // offer one byte transaction, then either keep the burst going or idle a while
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid <= 1'b1;
    in_code_byte <= b;
    in_end_of_code <= last;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) end_flags_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 10);
    end
  endtask

  // stop offering and wait until every queued record has been taken
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (awaited != 0);
  endtask

  // one instruction of the given form with random fields, sometimes cut by an end flag
  task automatic send_instruction(input x86d_pkg::kind_t form);
    logic [7:0] op;
    logic [7:0] modrm;
    int         n_tail;
    int         cut;
    logic       stop;
    n_tail = 0;
    instr_bytes.delete();
    case (form)
      x86d_pkg::KIND_MOV_RM:  op = x86d_pkg::MOV_RM_PREFIX | 8'($urandom_range(0, 3));
      x86d_pkg::KIND_MOV_IMM: op = x86d_pkg::MOV_IMM_PREFIX | 8'($urandom_range(0, 15));
      x86d_pkg::KIND_ADD_RM:  op = 8'($urandom_range(0, 3));
      x86d_pkg::KIND_ADD_IMM: op = x86d_pkg::ADD_IMM_PREFIX | 8'($urandom_range(0, 3));
      x86d_pkg::KIND_ADD_ACC: op = x86d_pkg::ADD_ACC_PREFIX | 8'($urandom_range(0, 1));
      default: op = $urandom_range(0, 1) ? 8'($urandom_range(8'h06, 8'h7F))
                                         : 8'($urandom_range(8'hC0, 8'hFF));
    endcase
    instr_bytes.push_back(op);
    case (form)
      x86d_pkg::KIND_MOV_RM, x86d_pkg::KIND_ADD_RM, x86d_pkg::KIND_ADD_IMM: begin
        modrm = 8'($urandom);
        // bias toward the direct address form
        if ($urandom_range(0, 7) == 0) modrm = {2'b00, modrm[5:3], 3'b110};
        instr_bytes.push_back(modrm);
        case (modrm[7:6])
          2'd1:    n_tail = 1;
          2'd2:    n_tail = 2;
          2'd0:    n_tail = (modrm[2:0] == 3'b110) ? 2 : 0;
          default: n_tail = 0;
        endcase
      end
      x86d_pkg::KIND_UNKNOWN: n_tail = 1;
      default: ;
    endcase
    case (form)
      x86d_pkg::KIND_MOV_IMM: n_tail += op[3] ? 2 : 1;
      x86d_pkg::KIND_ADD_IMM: n_tail += (op[1:0] == 2'b01) ? 2 : 1;
      x86d_pkg::KIND_ADD_ACC: n_tail += op[0] ? 2 : 1;
      default: ;
    endcase
    repeat (n_tail) instr_bytes.push_back(8'($urandom));
    cut = instr_bytes.size();
    stop = 1'b0;
    if ($urandom_range(0, 24) == 0) begin
      cut = $urandom_range(1, instr_bytes.size());
      stop = 1'b1;
    end
    for (int i = 0; i < cut; i++) send_byte(instr_bytes[i], stop && (i == cut - 1));
  endtask

  // stimulus and verdict
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED_BYTES); i++) begin
      send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
    end

    // mostly well-formed instructions, some stray bytes with an occasional end flag
    while (bytes_sent < ITEM_TARGET) begin
      if (!paused && bytes_sent >= ITEM_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        send_instruction(x86d_pkg::kind_t'($urandom_range(0, 5)));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("run: %0d code bytes sent, %0d carrying the end flag", bytes_sent,
             end_flags_sent);
    $display("run: %0d decoded records compared, %0d mismatches", records_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
